### sv/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define AST_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define AST_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/usrt_pkg.sv
// Constants and codes for the unordered swap-remove table.
package usrt_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

endpackage

### sv/unordered_swap_remove_table.sv
// Unordered swap-remove table: slot memory, fill count and command sequencer.
// Push, clear and any rejected command give their result in the cycle after they are taken.
// Remove runs in steps: read the slot, read the last slot, write the move-down.
// Search reads one slot per cycle on the single memory read port.
// busy is high while a remove or search runs; the next item is taken at the edge ending done.
// Reset (rst, synchronous) empties the table at once; slot contents are not cleared.
module unordered_swap_remove_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       command,
  input  logic [usrt_pkg::DATA_WIDTH-1:0]  data_in,
  input  logic [usrt_pkg::IDX_W-1:0]       index_in,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [usrt_pkg::IDX_W-1:0]       index_out,
  output logic [usrt_pkg::DATA_WIDTH-1:0]  data_out,
  output logic [usrt_pkg::CNT_W-1:0]       count_out
);

  typedef enum logic [1:0] {IDLE, RM_TAKE, RM_MOVE, SRCH} state_t;

  state_t                             state;
  logic [usrt_pkg::CNT_W-1:0]         count;
  logic [usrt_pkg::IDX_W-1:0]         ptr;
  logic [usrt_pkg::DATA_WIDTH-1:0]    key;
  logic [usrt_pkg::DATA_WIDTH-1:0]    taken;

  state_t                             state_next;
  logic [usrt_pkg::CNT_W-1:0]         count_next;
  logic [usrt_pkg::IDX_W-1:0]         ptr_next;
  logic [usrt_pkg::DATA_WIDTH-1:0]    key_next;
  logic [usrt_pkg::DATA_WIDTH-1:0]    taken_next;
  logic                               done_next;
  logic [1:0]                         status_next;
  logic [usrt_pkg::IDX_W-1:0]         index_out_next;
  logic [usrt_pkg::DATA_WIDTH-1:0]    data_out_next;
  logic [usrt_pkg::CNT_W-1:0]         count_out_next;

  logic [usrt_pkg::DATA_WIDTH-1:0]    mem [usrt_pkg::CAPACITY];
  logic [usrt_pkg::DATA_WIDTH-1:0]    rdata;
  logic [usrt_pkg::IDX_W-1:0]         raddr;
  logic [usrt_pkg::IDX_W-1:0]         waddr;
  logic [usrt_pkg::DATA_WIDTH-1:0]    wdata;
  logic                               we;

  logic                               accept;
  logic                               full;
  logic                               rm_bad;
  logic [usrt_pkg::IDX_W-1:0]         last;
  logic [usrt_pkg::CNT_W-1:0]         ptr_inc;

  assign accept  = start && (state == IDLE);
  assign busy    = (state != IDLE);
  assign full    = (count >= usrt_pkg::CAP_COUNT);
  assign rm_bad  = ({1'b0, index_in} >= count);
  assign last    = usrt_pkg::IDX_W'(count - 1'b1);
  assign ptr_inc = {1'b0, ptr} + 1'b1;

  always_comb begin
    case (state)
      IDLE:    raddr = (command == usrt_pkg::CMD_REMOVE) ? index_in : '0;
      RM_TAKE: raddr = last;
      SRCH:    raddr = usrt_pkg::IDX_W'(ptr_inc);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = usrt_pkg::IDX_W'(count);
    wdata = data_in;
    if (state == RM_MOVE) begin
      we    = 1'b1;
      waddr = ptr;
      wdata = rdata;
    end else if (accept && command == usrt_pkg::CMD_PUSH && !full) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ptr_next       = ptr;
    key_next       = key;
    taken_next     = taken;
    done_next      = 1'b0;
    status_next    = usrt_pkg::ST_OK;
    index_out_next = '0;
    data_out_next  = '0;
    count_out_next = count_out;
    case (state)
      IDLE: begin
        if (accept) begin
          key_next = data_in;
          case (command)
            usrt_pkg::CMD_PUSH: begin
              done_next = 1'b1;
              if (full) begin
                status_next    = usrt_pkg::ST_FULL;
                count_out_next = count;
              end else begin
                index_out_next = usrt_pkg::IDX_W'(count);
                count_next     = count + 1'b1;
                count_out_next = count + 1'b1;
              end
            end
            usrt_pkg::CMD_REMOVE: begin
              ptr_next = index_in;
              if (rm_bad) begin
                done_next      = 1'b1;
                status_next    = usrt_pkg::ST_RANGE;
                count_out_next = count;
              end else begin
                state_next = RM_TAKE;
              end
            end
            usrt_pkg::CMD_SEARCH: begin
              ptr_next = '0;
              if (count == '0) begin
                done_next      = 1'b1;
                status_next    = usrt_pkg::ST_NOT_FOUND;
                count_out_next = count;
              end else begin
                state_next = SRCH;
              end
            end
            default: begin
              done_next      = 1'b1;
              count_next     = '0;
              count_out_next = '0;
            end
          endcase
        end
      end
      RM_TAKE: begin
        taken_next = rdata;
        state_next = RM_MOVE;
      end
      RM_MOVE: begin
        done_next      = 1'b1;
        data_out_next  = taken;
        count_next     = count - 1'b1;
        count_out_next = count - 1'b1;
        state_next     = IDLE;
      end
      SRCH: begin
        if (rdata == key) begin
          done_next      = 1'b1;
          index_out_next = ptr;
          count_out_next = count;
          state_next     = IDLE;
        end else if (ptr_inc == count) begin
          done_next      = 1'b1;
          status_next    = usrt_pkg::ST_NOT_FOUND;
          count_out_next = count;
          state_next     = IDLE;
        end else begin
          ptr_next = usrt_pkg::IDX_W'(ptr_inc);
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      done      <= 1'b0;
      status    <= usrt_pkg::ST_OK;
      index_out <= '0;
      data_out  <= '0;
      count_out <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ptr       <= ptr_next;
      key       <= key_next;
      taken     <= taken_next;
      done      <= done_next;
      status    <= status_next;
      index_out <= index_out_next;
      data_out  <= data_out_next;
      count_out <= count_out_next;
    end
  end

endmodule

### sv/usrt_checker.sv
// Port-level checker for the swap-remove table, bound into the table module.
`include "assert_macros.svh"

module usrt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic [1:0]                       command,
  input logic                             done,
  input logic [1:0]                       status,
  input logic [usrt_pkg::IDX_W-1:0]       index_out,
  input logic [usrt_pkg::DATA_WIDTH-1:0]  data_out,
  input logic [usrt_pkg::CNT_W-1:0]       count_out
);

  `AST_CLK(a_quick_cmd, start && !busy && (command == usrt_pkg::CMD_PUSH || command == usrt_pkg::CMD_CLEAR) |=> done, "push or clear gave no result next cycle")
  `AST_CLK(a_clear_empty, start && !busy && command == usrt_pkg::CMD_CLEAR |=> count_out == '0, "clear left a nonzero count")
  `AST_CLK(a_err_zero, done && status != usrt_pkg::ST_OK |-> index_out == '0 && data_out == '0, "rejected item carries nonzero payload")
  `AST_CLK(a_full_count, done && status == usrt_pkg::ST_FULL |-> count_out == usrt_pkg::CAP_COUNT, "full reported below capacity")
  `AST_CLK(a_count_cap, count_out <= usrt_pkg::CAP_COUNT, "count beyond capacity")

endmodule

bind unordered_swap_remove_table usrt_checker u_usrt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .command   (command),
  .done      (done),
  .status    (status),
  .index_out (index_out),
  .data_out  (data_out),
  .count_out (count_out)
);

### bench/usrt_reply_checker.sv
// Reply checker for the swap-remove table: shadow table, expected replies, field compare.
`timescale 1ns / 1ps

module usrt_reply_checker
  import usrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            command,
  input  logic [DATA_WIDTH-1:0] data_in,
  input  logic [IDX_W-1:0]      index_in,
  input  logic                  done,
  input  logic [1:0]            status,
  input  logic [IDX_W-1:0]      index_out,
  input  logic [DATA_WIDTH-1:0] data_out,
  input  logic [CNT_W-1:0]      count_out,
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic [1:0]            status;
    logic [IDX_W-1:0]      index;
    logic [DATA_WIDTH-1:0] word;
    logic [CNT_W-1:0]      count;
  } reply_t;

  logic [DATA_WIDTH-1:0] shadow_slots [CAPACITY];
  int unsigned           shadow_fill;
  reply_t                replies_due [$];
  int                    mismatch_count;

  assign failures = mismatch_count;

  initial begin
    shadow_fill    = 0;
    mismatch_count = 0;
    pending        = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic reply_t apply_command(input logic [1:0] cmd,
                                           input logic [DATA_WIDTH-1:0] word,
                                           input logic [IDX_W-1:0] slot);
    reply_t r;
    int     hit;
    r   = '0;
    hit = -1;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_slots[shadow_fill] = word;
          r.status = ST_OK;
          r.index  = IDX_W'(shadow_fill);
          shadow_fill++;
        end
      end
      CMD_REMOVE: begin
        if (slot >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_OK;
          r.word   = shadow_slots[slot];
          shadow_slots[slot] = shadow_slots[shadow_fill - 1];
          shadow_fill--;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (hit < 0 && shadow_slots[i] == word) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status = ST_OK;
          r.index  = IDX_W'(hit);
        end
      end
      default: begin
        shadow_fill = 0;
        r.status = ST_OK;
      end
    endcase
    r.count = CNT_W'(shadow_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (done) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("done with no reply due (status %0d count %0d)",
                                    status, count_out));
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status, want.status));
          if (index_out !== want.index)
            report_mismatch($sformatf("index_out got %0d want %0d", index_out, want.index));
          if (data_out !== want.word)
            report_mismatch($sformatf("data_out got %h want %h", data_out, want.word));
          if (count_out !== want.count)
            report_mismatch($sformatf("count_out got %0d want %0d", count_out, want.count));
        end
      end
      if (start && !busy) begin
        replies_due.push_back(apply_command(command, data_in, index_in));
      end
    end
    pending <= replies_due.size();
  end

endmodule

### bench/unordered_swap_remove_table_test.sv
// Testbench top for the swap-remove table: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module unordered_swap_remove_table_test;
  import usrt_pkg::*;

  localparam int RANDOM_ITEMS = 530;
  localparam int CYCLE_LIMIT  = 400000;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            command;
  logic [DATA_WIDTH-1:0] data_in;
  logic [IDX_W-1:0]      index_in;
  logic                  done;
  logic [1:0]            status;
  logic [IDX_W-1:0]      index_out;
  logic [DATA_WIDTH-1:0] data_out;
  logic [CNT_W-1:0]      count_out;
  int                    failures;
  int                    pending;

  int                    items_sent;
  int                    cycles;
  logic [DATA_WIDTH-1:0] word_pool [8];

  unordered_swap_remove_table dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .data_in   (data_in),
    .index_in  (index_in),
    .done      (done),
    .status    (status),
    .index_out (index_out),
    .data_out  (data_out),
    .count_out (count_out)
  );

  usrt_reply_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .data_in   (data_in),
    .index_in  (index_in),
    .done      (done),
    .status    (status),
    .index_out (index_out),
    .data_out  (data_out),
    .count_out (count_out),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    if ($urandom_range(99) < 70) return word_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic [IDX_W-1:0] pick_slot();
    if ($urandom_range(1) == 0) return IDX_W'($urandom_range(15));
    return IDX_W'($urandom_range(CAPACITY - 1));
  endfunction

  function automatic logic [1:0] pick_command(input int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (r < 75) return CMD_PUSH;
        if (r < 87) return CMD_SEARCH;
        return CMD_REMOVE;
      end
      MODE_DRAIN: begin
        if (r < 55) return CMD_REMOVE;
        if (r < 85) return CMD_SEARCH;
        return CMD_PUSH;
      end
      default: begin
        if (r < 3)  return CMD_CLEAR;
        if (r < 38) return CMD_PUSH;
        if (r < 68) return CMD_REMOVE;
        return CMD_SEARCH;
      end
    endcase
  endfunction

  // after an optional idle gap, holds start high until the item is taken at an edge with busy low
  task automatic send_item(input logic [1:0] cmd, input logic [DATA_WIDTH-1:0] word,
                           input logic [IDX_W-1:0] slot);
    int gap;
    if (!(items_sent >= 200 && items_sent < 330) && $urandom_range(99) < 22) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    command  <= cmd;
    data_in  <= word;
    index_in <= slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int mode;
    int len;
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;
    word_pool[2] = 32'h0000_0001;
    word_pool[3] = 32'h8000_0000;
    word_pool[4] = 32'hA5A5_A5A5;
    word_pool[5] = 32'h5A5A_5A5A;
    word_pool[6] = 32'h0000_FFFF;
    word_pool[7] = 32'hFFFF_0000;
    items_sent = 0;
    rst      <= 1'b1;
    start    <= 1'b0;
    command  <= CMD_PUSH;
    data_in  <= '0;
    index_in <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_item(CMD_PUSH,   32'h0000_0000, 6'd63);
    send_item(CMD_PUSH,   32'hFFFF_FFFF, 6'd0);
    send_item(CMD_PUSH,   32'h0000_0000, 6'd63);
    send_item(CMD_SEARCH, 32'h0000_0000, 6'd0);
    send_item(CMD_SEARCH, 32'hFFFF_FFFF, 6'd63);
    send_item(CMD_SEARCH, 32'h1234_5678, 6'd0);
    send_item(CMD_REMOVE, 32'hFFFF_FFFF, 6'd63);
    send_item(CMD_REMOVE, 32'h0000_0000, 6'd3);
    send_item(CMD_REMOVE, 32'h0000_0000, 6'd2);
    send_item(CMD_REMOVE, 32'h0000_0000, 6'd0);
    send_item(CMD_SEARCH, 32'hFFFF_FFFF, 6'd0);
    send_item(CMD_PUSH,   32'hA5A5_A5A5, 6'd0);
    send_item(CMD_CLEAR,  32'hFFFF_FFFF, 6'd63);
    send_item(CMD_REMOVE, 32'h0000_0000, 6'd0);
    send_item(CMD_SEARCH, 32'hA5A5_A5A5, 6'd0);
    send_item(CMD_PUSH,   32'h8000_0001, 6'd0);
    send_item(CMD_REMOVE, 32'h0000_0000, 6'd1);
    send_item(CMD_REMOVE, 32'h0000_0000, 6'd0);
    drain_replies();

    // fill past capacity, then random phases
    send_item(CMD_CLEAR, $urandom, pick_slot());
    repeat (CAPACITY + 3) send_item(CMD_PUSH, pick_word(), pick_slot());
    send_item(CMD_SEARCH, pick_word(), pick_slot());
    send_item(CMD_REMOVE, $urandom, 6'd63);
    send_item(CMD_PUSH, $urandom, pick_slot());
    while (items_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(2);
      len  = $urandom_range(30, 90);
      repeat (len) begin
        send_item(pick_command(mode), pick_word(), pick_slot());
      end
      if ($urandom_range(2) == 0) drain_replies();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/usrt_pkg.sv
sv/unordered_swap_remove_table.sv
sv/usrt_checker.sv
bench/usrt_reply_checker.sv
bench/unordered_swap_remove_table_test.sv
